// File: sv/brld_pkg.sv
// ----------------------------------------------------------------------------
// brld_pkg
// Shared constants and types for the byte run-length decoder.
// ----------------------------------------------------------------------------
package brld_pkg;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 7;

   // header byte fields
   localparam int REPEAT_BIT = 7;
   localparam logic [COUNT_W-1:0] COUNT_MASK = 7'd127;

   // most repeat copies sent out for the beat that carries the value
   localparam logic [COUNT_W-1:0] BURST = 7'd64;

   // one result beat handed to the output stage
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
      logic              last;
   } brld_beat_type;

endpackage

// File: sv/brld_if.sv
// ----------------------------------------------------------------------------
// brld request / response channels
// Valid/ready channels for compressed input bytes and decoded output bytes.
// ----------------------------------------------------------------------------
interface brld_req_if import brld_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface brld_rsp_if import brld_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              run_end;

   modport source (output valid, output out_byte, output run_end, input ready);
   modport sink   (input valid, input out_byte, input run_end, output ready);
endinterface

// File: sv/brld_out_stage.sv
// ----------------------------------------------------------------------------
// brld_out_stage
// Output register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module brld_out_stage
   import brld_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  brld_beat_type beat,
   output logic          slot_free,
   brld_rsp_if.source    rsp_ch
);

   logic              valid_ff;
   logic [BYTE_W-1:0] data_ff;
   logic              last_ff;

   // slot can take a new beat when empty or being drained this cycle
   assign slot_free = !valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (slot_free) begin
         valid_ff <= beat.valid;
      end
      if (slot_free && beat.valid) begin
         data_ff <= beat.data;
         last_ff <= beat.last;
      end
   end

   assign rsp_ch.valid    = valid_ff;
   assign rsp_ch.out_byte = data_ff;
   assign rsp_ch.run_end  = last_ff;

endmodule

// File: sv/byte_run_length_decoder.sv
// ----------------------------------------------------------------------------
// byte_run_length_decoder
// Decodes a byte-oriented run-length stream into plain bytes.
// ----------------------------------------------------------------------------
// A header byte with bit 7 set starts a repeat run of (byte & 127) copies of
// the next byte; with bit 7 clear it starts a literal run of that many bytes
// passed through as they arrive. Header and value bytes produce nothing;
// each literal byte produces one output beat in the following cycle, so
// literal data streams at one byte per clock while the sink is ready. A
// repeat run stalls the input while the copy counter drains one beat per
// clock into the output register, when it has room. At most 64 copies go
// out after the value byte; the rest of a longer run is held and sent once
// the following header byte is taken, and the byte after that header waits
// for them. The output beat with the last byte of each run carries run_end.
// A count of zero produces no beats. The output register holds one beat;
// while it is full and the sink is not ready, all input is held off,
// header and value bytes included.
// ----------------------------------------------------------------------------
module byte_run_length_decoder
   import brld_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   brld_req_if.sink   req_ch,
   brld_rsp_if.source rsp_ch
);

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_VALUE   = 2'd1,
      PH_LITERAL = 2'd2
   } phase_type;

   phase_type          phase_ff,   phase_in;
   logic [COUNT_W-1:0] remain_ff,  remain_in;   // count from the header
   logic [COUNT_W-1:0] rep_cnt_ff, rep_cnt_in;  // copies to send now
   logic [COUNT_W-1:0] held_ff,    held_in;     // copies held for next beat
   logic [BYTE_W-1:0]  value_ff,   value_in;    // byte being repeated

   brld_beat_type beat;
   logic          slot_free;
   logic          accept;
   logic [COUNT_W-1:0] count;

   // input waits while repeat copies drain or the output cannot take a beat
   assign req_ch.ready = (rep_cnt_ff == '0) && slot_free;
   assign accept       = req_ch.valid && req_ch.ready;
   assign count        = req_ch.in_byte[COUNT_W-1:0] & COUNT_MASK;

   always_comb begin
      phase_in   = phase_ff;
      remain_in  = remain_ff;
      rep_cnt_in = rep_cnt_ff;
      held_in    = held_ff;
      value_in   = value_ff;
      beat       = '0;

      if (rep_cnt_ff != '0) begin
         // repeat drain: one copy per free output slot
         if (slot_free) begin
            beat.valid = 1'b1;
            beat.data  = value_ff;
            beat.last  = (rep_cnt_ff == COUNT_W'(1)) && (held_ff == '0);
            rep_cnt_in = rep_cnt_ff - COUNT_W'(1);
         end
      end else if (accept) begin
         // leftover copies of a long run go out ahead of this beat
         if (held_ff != '0) begin
            rep_cnt_in = held_ff;
            held_in    = '0;
         end
         case (phase_ff)
            PH_VALUE: begin
               value_in  = req_ch.in_byte;
               if (remain_ff > BURST) begin
                  rep_cnt_in = BURST;
                  held_in    = remain_ff - BURST;
               end else begin
                  rep_cnt_in = remain_ff;
                  held_in    = '0;
               end
               remain_in = '0;
               phase_in  = PH_HEADER;
            end
            PH_LITERAL: begin
               beat.valid = 1'b1;
               beat.data  = req_ch.in_byte;
               beat.last  = (remain_ff == COUNT_W'(1));
               remain_in  = remain_ff - COUNT_W'(1);
               if (remain_ff == COUNT_W'(1)) begin
                  phase_in = PH_HEADER;
               end
            end
            default: begin
               // header; unused phase code decodes as header too
               remain_in = count;
               if (req_ch.in_byte[REPEAT_BIT]) begin
                  phase_in = PH_VALUE;
               end else if (count != '0) begin
                  phase_in = PH_LITERAL;
               end else begin
                  phase_in = PH_HEADER;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         remain_ff  <= '0;
         rep_cnt_ff <= '0;
         held_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         remain_ff  <= remain_in;
         rep_cnt_ff <= rep_cnt_in;
         held_ff    <= held_in;
      end
      value_ff <= value_in;
   end

   brld_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .beat      (beat),
      .slot_free (slot_free),
      .rsp_ch    (rsp_ch)
   );

endmodule

// File: sv/brld_checker.sv
// ----------------------------------------------------------------------------
// brld_checker
// Port-level checks for the byte run-length decoder, bound to the top level.
// ----------------------------------------------------------------------------
module brld_checker
   import brld_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BYTE_W-1:0] out_byte,
   input logic              run_end
);

   // stalled output beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(run_end))
      else $error("output beat changed while stalled");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

   // a stalled output register blocks new input
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

   // input held off with an empty output only while copies are pending
   a_drain_progress: assert property (@(posedge clock) disable iff (reset)
      !req_ready && !rsp_valid |=> rsp_valid)
      else $error("repeat drain made no progress");

endmodule

bind byte_run_length_decoder brld_checker u_brld_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .out_byte  (rsp_ch.out_byte),
   .run_end   (rsp_ch.run_end)
);
